// ===== rtl/attached_device_table_macros.svh =====
// Assertion macros for the attached device table checker.
`ifndef ATTACHED_DEVICE_TABLE_MACROS_SVH
`define ATTACHED_DEVICE_TABLE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ADT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ADT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/adt_pkg.sv =====
// Shared constants and types for the attached device table.
package adt_pkg;
	localparam int MAX_ENTRIES = 16;
	localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	localparam logic [1:0] OP_ATTACH = 2'd0;
	localparam logic [1:0] OP_DETACH = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;
	localparam logic [1:0] OP_STATUS = 2'd3;

	localparam logic [1:0] STS_OK = 2'd0;
	localparam logic [1:0] STS_FULL = 2'd1;
	localparam logic [1:0] STS_NOMATCH = 2'd2;
	localparam logic [1:0] STS_EMPTY = 2'd3;

	localparam logic [1:0] FLAG_NONE = 2'd0;
	localparam logic [1:0] FLAG_ADDED = 2'd1;
	localparam logic [1:0] FLAG_REMOVED = 2'd2;

	typedef struct packed {
		logic [15:0] vendor;
		logic [15:0] product;
	} entry_t;

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;
endpackage

// ===== rtl/attached_device_table.sv =====
// Attached device table: packed vendor/product table in one synchronous RAM.
//
// Command channel: start with opcode, vendor_id, product_id, slot_index is
// taken when busy is low. busy rises the next cycle and stays high until the
// result is delivered. Result channel: done is high for exactly one cycle
// with status, entry_vendor, entry_product, entry_position, device_count and
// change_flag; the receiver must take it then, there is no back-pressure.
// busy drops in the same cycle that done is high, so a new command can be
// accepted while the previous result is still on the ports.
// Path through the states, by command:
//   attach, read status, read of an unoccupied slot: execute state only
//   read entry: execute, then readout
//   detach: execute, search, then shift on a hit; a miss or an empty table ends in search
// A new command is taken only while busy is low; the next transfer can land on the
// edge that takes the result.
// The detach search and the shift of later entries each stream through the
// single RAM, one entry per cycle, through its registered read port; the shift
// writes entry k+1 into slot k while reading entry k+2.
// Reset clears the count, the change flag and the control state; the RAM is
// not cleared, only occupied slots are ever read.
module attached_device_table
	import adt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [15:0] vendor_id,
	input  logic [15:0] product_id,
	input  logic [3:0]  slot_index,
	output logic        done,
	output logic [1:0]  status,
	output logic [15:0] entry_vendor,
	output logic [15:0] entry_product,
	output logic [3:0]  entry_position,
	output logic [4:0]  device_count,
	output logic [1:0]  change_flag
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_SEARCH = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_RDOUT = 3'd4;
	localparam int CW = CNT_W + 4;

	entry_t mem [MAX_ENTRIES];

	logic [2:0]  state_q;
	logic [1:0]  op_q;
	entry_t      key_q;
	logic [3:0]  slot_q;
	cnt_t        count_q;
	logic [1:0]  flag_q;
	cnt_t        idx_q;
	cnt_t        pos_q;
	logic        pend_s1;
	cnt_t        addr_s1;
	entry_t      rdata_s1;
	logic        done_q;
	logic [1:0]  status_q;
	logic [15:0] vendor_q;
	logic [15:0] product_q;
	logic [3:0]  position_q;
	logic [1:0]  flag_out_q;

	logic        mem_re;
	addr_t       rd_addr;
	logic        mem_we;
	addr_t       wr_addr;
	entry_t      wr_data;
	logic        more;
	logic        hit;
	logic        slot_ok;
	logic        full;
	cnt_t        shift_dst;

	assign more = idx_q < count_q;
	assign hit = pend_s1 && (rdata_s1 == key_q);
	assign slot_ok = (CW'(slot_q) < CW'(count_q)) && (CW'(slot_q) < CW'(MAX_ENTRIES));
	assign full = count_q >= CNT_W'(MAX_ENTRIES);
	assign shift_dst = addr_s1 - 1'b1;

	always_comb begin
		mem_re = 1'b0;
		rd_addr = idx_q[ADDR_W-1:0];
		mem_we = 1'b0;
		wr_addr = count_q[ADDR_W-1:0];
		wr_data = key_q;
		unique case (state_q)
			S_EXEC: begin
				if (op_q == OP_READ && slot_ok) begin
					mem_re = 1'b1;
					rd_addr = ADDR_W'(slot_q);
				end
				if (op_q == OP_ATTACH && !full) begin
					mem_we = 1'b1;
				end
			end
			S_SEARCH: begin
				mem_re = more && !hit;
			end
			S_SHIFT: begin
				mem_re = more;
				if (pend_s1) begin
					mem_we = 1'b1;
					wr_addr = shift_dst[ADDR_W-1:0];
					wr_data = rdata_s1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		if (mem_re) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= idx_q;
		if (start && !busy) begin
			op_q <= opcode;
			key_q <= '{vendor: vendor_id, product: product_id};
			slot_q <= slot_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			flag_q <= FLAG_NONE;
			idx_q <= '0;
			pos_q <= '0;
			pend_s1 <= 1'b0;
			done_q <= 1'b0;
			status_q <= STS_OK;
			vendor_q <= '0;
			product_q <= '0;
			position_q <= '0;
			flag_out_q <= FLAG_NONE;
		end else begin
			done_q <= 1'b0;
			pend_s1 <= mem_re;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					vendor_q <= '0;
					product_q <= '0;
					position_q <= '0;
					status_q <= STS_OK;
					flag_out_q <= flag_q;
					unique case (op_q)
						OP_ATTACH: begin
							state_q <= S_IDLE;
							done_q <= 1'b1;
							if (full) begin
								status_q <= STS_FULL;
							end else begin
								position_q <= 4'(count_q);
								count_q <= count_q + 1'b1;
								flag_q <= FLAG_ADDED;
								flag_out_q <= FLAG_ADDED;
							end
						end
						OP_DETACH: begin
							idx_q <= '0;
							state_q <= S_SEARCH;
						end
						OP_READ: begin
							if (slot_ok) begin
								state_q <= S_RDOUT;
							end else begin
								state_q <= S_IDLE;
								done_q <= 1'b1;
								status_q <= STS_EMPTY;
								position_q <= slot_q;
							end
						end
						default: begin
							state_q <= S_IDLE;
							done_q <= 1'b1;
							flag_q <= FLAG_NONE;
						end
					endcase
				end
				S_SEARCH: begin
					if (hit) begin
						pos_q <= addr_s1;
						idx_q <= addr_s1 + 1'b1;
						state_q <= S_SHIFT;
					end else if (!more && !pend_s1) begin
						state_q <= S_IDLE;
						done_q <= 1'b1;
						status_q <= STS_NOMATCH;
					end else if (more) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_SHIFT: begin
					if (more) begin
						idx_q <= idx_q + 1'b1;
					end else if (!pend_s1) begin
						state_q <= S_IDLE;
						done_q <= 1'b1;
						status_q <= STS_OK;
						position_q <= 4'(pos_q);
						count_q <= count_q - 1'b1;
						flag_q <= FLAG_REMOVED;
						flag_out_q <= FLAG_REMOVED;
					end
				end
				S_RDOUT: begin
					state_q <= S_IDLE;
					done_q <= 1'b1;
					status_q <= STS_OK;
					vendor_q <= rdata_s1.vendor;
					product_q <= rdata_s1.product;
					position_q <= slot_q;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign status = status_q;
	assign entry_vendor = vendor_q;
	assign entry_product = product_q;
	assign entry_position = position_q;
	assign device_count = 5'(count_q);
	assign change_flag = flag_out_q;
endmodule

// ===== rtl/adt_checker.sv =====
// Port-level checker for the attached device table, bound to the top level.
`include "attached_device_table_macros.svh"

module adt_checker
	import adt_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  status,
	input logic [15:0] entry_vendor,
	input logic [15:0] entry_product
);
	`ADT_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted command did not raise busy")
	`ADT_ASSERT_IMP(a_done_idle, done, !busy, "result strobe while still busy")
	`ADT_ASSERT_IMP(a_fell_done, $fell(busy), done, "busy dropped without a result")
	`ADT_ASSERT_IMP(a_empty_zero, done && status == STS_EMPTY,
		entry_vendor == 16'd0 && entry_product == 16'd0, "unoccupied slot read returned data")
endmodule

bind attached_device_table adt_checker u_adt_checker (.*);

// ===== bench/attached_device_table_tb.sv =====
// Self-checking testbench for the attached device table: commands against a predictor.
`timescale 1ns / 100ps

module attached_device_table_tb;
	import adt_pkg::*;

	localparam int RANDOM_ITEMS = 650;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 60;
	localparam int POOL_SIZE = 6;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] ven;
		logic [15:0] prod;
		logic [3:0]  slot;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] ven;
		logic [15:0] prod;
		logic [3:0]  pos;
		logic [4:0]  count;
		logic [1:0]  flag;
	} reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  opcode = OP_STATUS;
	logic [15:0] vendor_id = '0;
	logic [15:0] product_id = '0;
	logic [3:0]  slot_index = '0;
	logic        done;
	logic [1:0]  status;
	logic [15:0] entry_vendor;
	logic [15:0] entry_product;
	logic [3:0]  entry_position;
	logic [4:0]  device_count;
	logic [1:0]  change_flag;

	cmd_t   cmd_pending[$];
	reply_t reply_expected[$];
	cmd_t   cur_cmd;
	int     mismatch_count = 0;
	int     burst_left = 1;
	int     gap_left = 0;
	int     idle_cycles = 0;

	// predicted device table
	entry_t     shadow_tbl[MAX_ENTRIES];
	cnt_t       shadow_cnt = '0;
	logic [1:0] shadow_flag = FLAG_NONE;

	attached_device_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.vendor_id(vendor_id),
		.product_id(product_id),
		.slot_index(slot_index),
		.done(done),
		.status(status),
		.entry_vendor(entry_vendor),
		.entry_product(entry_product),
		.entry_position(entry_position),
		.device_count(device_count),
		.change_flag(change_flag)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic reply_t table_update(cmd_t c);
		reply_t r;
		int     hit;
		int     i;
		r = '0;
		r.flag = shadow_flag;
		case (c.op)
			OP_ATTACH: begin
				if (shadow_cnt < MAX_ENTRIES) begin
					shadow_tbl[shadow_cnt].vendor = c.ven;
					shadow_tbl[shadow_cnt].product = c.prod;
					r.pos = shadow_cnt[3:0];
					shadow_cnt = shadow_cnt + 1'b1;
					shadow_flag = FLAG_ADDED;
				end else begin
					r.status = STS_FULL;
				end
				r.flag = shadow_flag;
			end
			OP_DETACH: begin
				hit = -1;
				for (i = 0; i < shadow_cnt; i++) begin
					if (hit < 0 && shadow_tbl[i].vendor == c.ven &&
						shadow_tbl[i].product == c.prod)
						hit = i;
				end
				if (hit >= 0) begin
					r.pos = hit[3:0];
					for (i = hit; i + 1 < shadow_cnt; i++)
						shadow_tbl[i] = shadow_tbl[i + 1];
					shadow_cnt = shadow_cnt - 1'b1;
					shadow_flag = FLAG_REMOVED;
				end else begin
					r.status = STS_NOMATCH;
				end
				r.flag = shadow_flag;
			end
			OP_READ: begin
				r.pos = c.slot;
				if (c.slot < shadow_cnt) begin
					r.ven = shadow_tbl[c.slot].vendor;
					r.prod = shadow_tbl[c.slot].product;
				end else begin
					r.status = STS_EMPTY;
				end
			end
			default: begin
				shadow_flag = FLAG_NONE;
			end
		endcase
		r.count = shadow_cnt;
		return r;
	endfunction

	task automatic report_error(string what, reply_t want, reply_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display({"%0t %s: exp sts=%0d ven=%h prod=%h pos=%0d cnt=%0d flag=%0d",
				" | got sts=%0d ven=%h prod=%h pos=%0d cnt=%0d flag=%0d"},
				$realtime, what, want.status, want.ven, want.prod, want.pos,
				want.count, want.flag,
				got.status, got.ven, got.prod, got.pos, got.count, got.flag);
	endtask

	task automatic queue_cmd(logic [1:0] op, logic [15:0] ven, logic [15:0] prod,
		logic [3:0] slot);
		cmd_t c;
		c.op = op;
		c.ven = ven;
		c.prod = prod;
		c.slot = slot;
		cmd_pending.push_back(c);
	endtask

	function automatic logic [15:0] rand_id();
		int pick;
		pick = $urandom_range(0, 7);
		if (pick == 0)
			return 16'hFFFF;
		else if (pick == 1)
			return 16'h0000;
		return 16'($urandom_range(0, 65535));
	endfunction

	// driver: bursts of transfers separated by random gaps
	always @(posedge clk) begin : driver
		cmd_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy)
				reply_expected.push_back(table_update(cur_cmd));
			if (start && busy) begin
				// hold the command until taken
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (cmd_pending.size() > 0) begin
				nxt = cmd_pending.pop_front();
				cur_cmd = nxt;
				opcode <= nxt.op;
				vendor_id <= nxt.ven;
				product_id <= nxt.prod;
				slot_index <= nxt.slot;
				start <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					if ($urandom_range(0, 15) == 0)
						gap_left = $urandom_range(20, 30);
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : monitor
		reply_t got;
		reply_t want;
		if (arst_n && done) begin
			got.status = status;
			got.ven = entry_vendor;
			got.prod = entry_product;
			got.pos = entry_position;
			got.count = device_count;
			got.flag = change_flag;
			if (reply_expected.size() == 0) begin
				report_error("unexpected result", '0, got);
			end else begin
				want = reply_expected.pop_front();
				if (got !== want)
					report_error("mismatch", want, got);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n) begin
			idle_cycles = 0;
		end else if ((start && !busy) || done) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t watchdog: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		entry_t id_pool[POOL_SIZE];
		entry_t e;
		int     n;
		int     phase_len;
		int     kind;
		int     r;
		int     i;

		// directed: empty table, extremes, partial match, duplicates, full table
		queue_cmd(OP_STATUS, 16'h0000, 16'h0000, 4'd0);
		queue_cmd(OP_READ, 16'h0000, 16'h0000, 4'd0);
		queue_cmd(OP_DETACH, 16'h1234, 16'h5678, 4'd0);
		queue_cmd(OP_ATTACH, 16'h0000, 16'h0000, 4'd15);
		queue_cmd(OP_ATTACH, 16'hFFFF, 16'hFFFF, 4'd0);
		queue_cmd(OP_ATTACH, 16'hFFFF, 16'h0000, 4'd0);
		queue_cmd(OP_DETACH, 16'hFFFF, 16'h1234, 4'd0);
		queue_cmd(OP_ATTACH, 16'hFFFF, 16'hFFFF, 4'd0);
		queue_cmd(OP_DETACH, 16'hFFFF, 16'hFFFF, 4'd0);
		queue_cmd(OP_READ, 16'h0000, 16'h0000, 4'd2);
		queue_cmd(OP_STATUS, 16'hFFFF, 16'hFFFF, 4'd15);
		e = '0;
		for (i = 0; i < 13; i++) begin
			e.vendor = 16'($urandom_range(0, 65535));
			e.product = 16'($urandom_range(0, 65535));
			queue_cmd(OP_ATTACH, e.vendor, e.product, 4'($urandom_range(0, 15)));
		end
		queue_cmd(OP_ATTACH, 16'hABCD, 16'h0001, 4'd0);
		queue_cmd(OP_READ, 16'h0000, 16'h0000, 4'd15);
		queue_cmd(OP_DETACH, e.vendor, e.product, 4'd0);
		queue_cmd(OP_STATUS, 16'h0000, 16'h0000, 4'd0);

		// random: phases that fill, drain or mix, over a small pool of identifiers
		for (i = 0; i < POOL_SIZE; i++) begin
			id_pool[i].vendor = rand_id();
			id_pool[i].product = rand_id();
		end
		n = 0;
		while (n < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 2);
			phase_len = $urandom_range(30, 70);
			for (i = 0; i < POOL_SIZE / 2; i++) begin
				r = $urandom_range(0, POOL_SIZE - 1);
				id_pool[r].vendor = rand_id();
				id_pool[r].product = rand_id();
			end
			repeat (phase_len) begin
				r = $urandom_range(0, 99);
				e = id_pool[$urandom_range(0, POOL_SIZE - 1)];
				if (r < ((kind == 0) ? 60 : (kind == 1) ? 20 : 35)) begin
					if ($urandom_range(0, 99) < 15) begin
						e.vendor = 16'($urandom_range(0, 65535));
						e.product = 16'($urandom_range(0, 65535));
					end
					queue_cmd(OP_ATTACH, e.vendor, e.product, 4'($urandom_range(0, 15)));
				end else if (r < ((kind == 0) ? 75 : (kind == 1) ? 70 : 60)) begin
					r = $urandom_range(0, 9);
					if (r == 0)
						e.product = 16'($urandom_range(0, 65535));
					else if (r == 1)
						e.vendor = 16'($urandom_range(0, 65535));
					queue_cmd(OP_DETACH, e.vendor, e.product, 4'($urandom_range(0, 15)));
				end else if (r < 90) begin
					queue_cmd(OP_READ, 16'($urandom_range(0, 65535)),
						16'($urandom_range(0, 65535)), 4'($urandom_range(0, 15)));
				end else begin
					queue_cmd(OP_STATUS, 16'($urandom_range(0, 65535)),
						16'($urandom_range(0, 65535)), 4'($urandom_range(0, 15)));
				end
				n++;
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_pending.size() != 0 || start || reply_expected.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (reply_expected.size() != 0)
			report_error("missing result", reply_expected[0], '0);

		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
